[hdl/srg_pkg.sv]
// Shared types and constants for the subtractive random generator.
`default_nettype none

package srg_pkg;

	localparam int LAG_WORDS    = 55;
	localparam int SCATTER      = 21;
	localparam int LAG_OFFSET   = 30;
	localparam int SECOND_START = 31;
	localparam int IDX_W        = 6;
	localparam int WORD_W       = 30;
	localparam int SEED_W       = 28;

	localparam logic [SEED_W-1:0] SEED_BASE  = 28'd161803398;
	localparam logic [SEED_W-1:0] SEED_RESET = 28'd996;
	localparam logic [WORD_W-1:0] MODULUS    = 30'd1000000000;

	typedef logic [WORD_W-1:0] word_t;
	typedef logic [IDX_W-1:0]  idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEED_INIT,
		ST_SEED_FILL,
		ST_WARM_RD,
		ST_WARM_WR,
		ST_DRAW_RD,
		ST_DRAW_WR
	} state_t;

	typedef struct packed {
		logic seed_load;
		logic fill_step;
		logic warm_rd;
		logic warm_wr;
		logic draw_rd;
		logic draw_wr;
	} cmd_t;

	typedef struct packed {
		logic fill_last;
		logic warm_last;
		logic out_free;
		idx_t ptr_first;
		idx_t ptr_second;
	} status_t;

endpackage

`default_nettype wire

[hdl/srg_ram.sv]
// Generic RAM: one write port, two registered read ports with enable.
`default_nettype none

module srg_ram #(
	parameter int WIDTH = 30,
	parameter int DEPTH = 55,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             wr_en,
	input  wire logic [AW-1:0]    wr_addr,
	input  wire logic [WIDTH-1:0] wr_data,
	input  wire logic             rd_en,
	input  wire logic [AW-1:0]    rd_addr_a,
	input  wire logic [AW-1:0]    rd_addr_b,
	output logic      [WIDTH-1:0] rd_data_a,
	output logic      [WIDTH-1:0] rd_data_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_a_q;
	logic [WIDTH-1:0] rd_b_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_a_q <= mem_q[rd_addr_a];
			rd_b_q <= mem_q[rd_addr_b];
		end
	end

	assign rd_data_a = rd_a_q;
	assign rd_data_b = rd_b_q;

endmodule

`default_nettype wire

[hdl/srg_ctrl.sv]
// Sequencer for seeding, warm-up passes and draws.
`default_nettype none

module srg_ctrl import srg_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    in_valid,
	input  wire logic    restart,
	output logic         in_stall,
	input  wire status_t st,
	output cmd_t         cmd
);

	state_t state_q;
	state_t state_nxt;
	logic   seeded_q;

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_nxt = (restart || !seeded_q) ? ST_SEED_INIT : ST_DRAW_RD;
				end
			end
			ST_SEED_INIT: state_nxt = ST_SEED_FILL;
			ST_SEED_FILL: begin
				if (st.fill_last) begin
					state_nxt = ST_WARM_RD;
				end
			end
			ST_WARM_RD: state_nxt = ST_WARM_WR;
			ST_WARM_WR: begin
				state_nxt = st.warm_last ? ST_DRAW_RD : ST_WARM_RD;
			end
			ST_DRAW_RD: state_nxt = ST_DRAW_WR;
			ST_DRAW_WR: begin
				if (st.out_free) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_stall = 1'b1;
		unique case (state_q)
			ST_IDLE:      in_stall = 1'b0;
			ST_SEED_INIT: cmd.seed_load = 1'b1;
			ST_SEED_FILL: cmd.fill_step = 1'b1;
			ST_WARM_RD:   cmd.warm_rd = 1'b1;
			ST_WARM_WR:   cmd.warm_wr = 1'b1;
			ST_DRAW_RD:   cmd.draw_rd = 1'b1;
			ST_DRAW_WR:   cmd.draw_wr = st.out_free;
			default:      in_stall = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			seeded_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (state_q == ST_WARM_WR && st.warm_last) begin
				seeded_q <= 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

[hdl/srg_dp.sv]
// Datapath: seed register, lag table, pointers, loop counters, output word.
`default_nettype none

module srg_dp import srg_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_write,
	input  wire logic [SEED_W-1:0] cfg_data,
	input  wire cmd_t              cmd,
	output status_t                st,
	input  wire logic              out_stall,
	output logic                   out_valid,
	output logic      [WORD_W-1:0] value
);

	function automatic word_t sub_mod(input word_t a, input word_t b);
		logic [WORD_W:0] d;
		d = {1'b0, a} - {1'b0, b};
		if (d[WORD_W]) begin
			d = d + {1'b0, MODULUS};
		end
		return d[WORD_W-1:0];
	endfunction

	function automatic idx_t advance(input idx_t p);
		return (p >= IDX_W'(LAG_WORDS)) ? IDX_W'(1) : p + IDX_W'(1);
	endfunction

	logic [SEED_W-1:0] seed_q;
	logic [SEED_W-1:0] seed_sat;
	word_t             prev0;

	word_t      prev_q, next_q, value_q;
	idx_t       slot_q, step_q, ptr_first_q, ptr_second_q;
	logic [1:0] pass_q;
	logic       out_valid_q;

	logic [IDX_W:0] slot_sum, part_sum;
	idx_t           slot_nxt, partner, first_nxt, second_nxt;

	logic  wr_en, rd_en;
	idx_t  wr_addr, rd_addr_a, rd_addr_b;
	word_t wr_data, rd_data_a, rd_data_b, diff;

	assign seed_sat = (seed_q > SEED_BASE) ? SEED_BASE : seed_q;
	assign prev0    = WORD_W'(SEED_BASE - seed_sat);

	// 21*i mod 55 scatter, stepped by addition
	assign slot_sum = {1'b0, slot_q} + (IDX_W+1)'(SCATTER);
	assign slot_nxt = (slot_sum >= (IDX_W+1)'(LAG_WORDS))
		? IDX_W'(slot_sum - (IDX_W+1)'(LAG_WORDS)) : IDX_W'(slot_sum);

	// RAM address of word 1 + (i+30) mod 55
	assign part_sum = {1'b0, step_q} + (IDX_W+1)'(LAG_OFFSET);
	assign partner  = (part_sum >= (IDX_W+1)'(LAG_WORDS))
		? IDX_W'(part_sum - (IDX_W+1)'(LAG_WORDS)) : IDX_W'(part_sum);

	assign first_nxt  = advance(ptr_first_q);
	assign second_nxt = advance(ptr_second_q);

	assign rd_en     = cmd.warm_rd | cmd.draw_rd;
	assign rd_addr_a = cmd.draw_rd ? first_nxt - IDX_W'(1) : step_q - IDX_W'(1);
	assign rd_addr_b = cmd.draw_rd ? second_nxt - IDX_W'(1) : partner;

	assign diff  = sub_mod(rd_data_a, rd_data_b);
	assign wr_en = cmd.seed_load | cmd.fill_step | cmd.warm_wr | cmd.draw_wr;

	always_comb begin
		priority if (cmd.seed_load) begin
			wr_addr = IDX_W'(LAG_WORDS - 1);
			wr_data = prev0;
		end else if (cmd.fill_step) begin
			wr_addr = slot_q - IDX_W'(1);
			wr_data = next_q;
		end else if (cmd.warm_wr) begin
			wr_addr = step_q - IDX_W'(1);
			wr_data = diff;
		end else begin
			wr_addr = ptr_first_q - IDX_W'(1);
			wr_data = diff;
		end
	end

	srg_ram #(
		.WIDTH(WORD_W),
		.DEPTH(LAG_WORDS)
	) u_table (
		.clk      (clk),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.wr_data  (wr_data),
		.rd_en    (rd_en),
		.rd_addr_a(rd_addr_a),
		.rd_addr_b(rd_addr_b),
		.rd_data_a(rd_data_a),
		.rd_data_b(rd_data_b)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q       <= SEED_RESET;
			ptr_first_q  <= '0;
			ptr_second_q <= IDX_W'(SECOND_START);
			step_q       <= '0;
			pass_q       <= '0;
			slot_q       <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_write) begin
				seed_q <= cfg_data;
			end
			if (cmd.seed_load) begin
				slot_q <= IDX_W'(SCATTER);
				step_q <= IDX_W'(1);
			end
			if (cmd.fill_step) begin
				slot_q <= slot_nxt;
				if (st.fill_last) begin
					step_q <= IDX_W'(1);
					pass_q <= '0;
				end else begin
					step_q <= step_q + IDX_W'(1);
				end
			end
			if (cmd.warm_wr) begin
				if (step_q == IDX_W'(LAG_WORDS)) begin
					step_q <= IDX_W'(1);
					pass_q <= pass_q + 2'd1;
				end else begin
					step_q <= step_q + IDX_W'(1);
				end
				if (st.warm_last) begin
					ptr_first_q  <= '0;
					ptr_second_q <= IDX_W'(SECOND_START);
				end
			end
			if (cmd.draw_rd) begin
				ptr_first_q  <= first_nxt;
				ptr_second_q <= second_nxt;
			end
			if (cmd.draw_wr) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.seed_load) begin
			prev_q <= prev0;
			next_q <= WORD_W'(1);
		end else if (cmd.fill_step) begin
			prev_q <= next_q;
			next_q <= sub_mod(prev_q, next_q);
		end
		if (cmd.draw_wr) begin
			value_q <= diff;
		end
	end

	assign st.fill_last  = (step_q == IDX_W'(LAG_WORDS - 1));
	assign st.warm_last  = (step_q == IDX_W'(LAG_WORDS)) && (pass_q == 2'd3);
	assign st.out_free   = !out_valid_q || !out_stall;
	assign st.ptr_first  = ptr_first_q;
	assign st.ptr_second = ptr_second_q;

	assign out_valid = out_valid_q;
	assign value     = value_q;

endmodule

`default_nettype wire

[hdl/subtractive_random_generator_core.sv]
// Subtractive lagged random generator, modulus 10^9, 55-word table.
// Input channel: in_valid/in_stall with one word carrying restart. Each
// accepted word asks for one draw; restart set (or no seed yet) reseeds first.
// Output channel: out_valid/out_stall with value, an integer in [0, 10^9).
// Config: cfg_write loads cfg_data as the seed magnitude; it is used at the
// next reseed. Write it only while the block is idle.
// A plain draw reads the two lag words through the registered read ports
// of the two-port table RAM, then writes the difference back to the table
// and into the output register; the next word is taken once that is done.
// A reseed first writes the top word, then does 54 scatter fills, then
// 4 warm-up passes of 55 read/write pairs on the table RAM.
// Only one word is in flight; in_stall is high from acceptance until the
// result sits in the output register. If the receiver stalls, the result
// holds and the sequencer waits before writing the table.
// Reset (arst_n low) clears the pointers to 0 and 31, marks the table
// unseeded and sets the seed magnitude to 996. The table is not cleared.
`default_nettype none

module subtractive_random_generator_core import srg_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_write,
	input  wire logic [SEED_W-1:0] cfg_data,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic              restart,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic      [WORD_W-1:0] value
);

	cmd_t    cmd;
	status_t st;

	srg_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.restart (restart),
		.in_stall(in_stall),
		.st      (st),
		.cmd     (cmd)
	);

	srg_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_write(cfg_write),
		.cfg_data (cfg_data),
		.cmd      (cmd),
		.st       (st),
		.out_stall(out_stall),
		.out_valid(out_valid),
		.value    (value)
	);

`ifndef NO_ASSERTIONS
	// one word in flight: the cycle after acceptance the input is held off
	a_single_word: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("second word accepted while busy");

	// a draw's table write-back always lands a word in the output register
	a_draw_out: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.draw_wr |=> out_valid)
		else $error("draw written without output word");

	// the two pointers stay 31 apart modulo 55
	a_ptr_lag: assert property (@(posedge clk) disable iff (!arst_n)
		(st.ptr_second == st.ptr_first + IDX_W'(SECOND_START)) ||
		(st.ptr_second == st.ptr_first - IDX_W'(LAG_WORDS - SECOND_START)))
		else $error("pointer lag broken");
`endif

endmodule

`default_nettype wire

[dv/tb_subtractive_random_generator_core.sv]
// Testbench for the subtractive random generator: scoreboard, stimulus and checks.
`timescale 1ns / 100ps

module tb_subtractive_random_generator_core;
	import srg_pkg::*;

	localparam int HOLD_CYCLES    = 300;
	localparam int ITEMS_PER_SEED = 275;
	localparam int RESTART_PCT    = 2;
	localparam int SETTLE_CYCLES  = 5;

	// Tracks the lag table and holds the values still to come out.
	class srg_scoreboard;
		int                taps [1:LAG_WORDS];
		int                first_ptr;
		int                second_ptr;
		bit                seeded;
		logic [SEED_W-1:0] seed_mag;
		word_t             pending_values [$];
		int                errors;

		function new();
			first_ptr  = 0;
			second_ptr = SECOND_START;
			seeded     = 1'b0;
			seed_mag   = SEED_RESET;
			errors     = 0;
		endfunction

		function int sub_mod(int a, int b);
			int d;
			d = a - b;
			if (d < 0) begin
				d += int'(MODULUS);
			end
			return d;
		endfunction

		function int step_ptr(int p);
			return (p >= LAG_WORDS) ? 1 : p + 1;
		endfunction

		function void set_seed(logic [SEED_W-1:0] mag);
			seed_mag = mag;
		endfunction

		function void note_draw(bit restart_req);
			int prev;
			int next;
			int slot;
			int d;
			if (restart_req || !seeded) begin
				// seed magnitude saturates so the top word stays non-negative
				prev = int'(SEED_BASE) - ((seed_mag > SEED_BASE) ? int'(SEED_BASE) : int'(seed_mag));
				taps[LAG_WORDS] = prev;
				next = 1;
				for (int i = 1; i < LAG_WORDS; i++) begin
					slot       = (SCATTER * i) % LAG_WORDS;
					taps[slot] = next;
					next       = sub_mod(prev, next);
					prev       = taps[slot];
				end
				for (int pass = 0; pass < 4; pass++) begin
					for (int i = 1; i <= LAG_WORDS; i++) begin
						taps[i] = sub_mod(taps[i], taps[1 + (i + LAG_OFFSET) % LAG_WORDS]);
					end
				end
				first_ptr  = 0;
				second_ptr = SECOND_START;
				seeded     = 1'b1;
			end
			first_ptr       = step_ptr(first_ptr);
			second_ptr      = step_ptr(second_ptr);
			d               = sub_mod(taps[first_ptr], taps[second_ptr]);
			taps[first_ptr] = d;
			pending_values.push_back(word_t'(d));
		endfunction

		function void check_value(word_t got);
			word_t want;
			if (pending_values.size() == 0) begin
				$error("value: no draw pending, actual %0d", got);
				errors++;
			end else begin
				want = pending_values.pop_front();
				if (got !== want) begin
					$error("value: expected %0d, actual %0d", want, got);
					errors++;
				end
			end
		endfunction

		function int outstanding();
			return pending_values.size();
		endfunction
	endclass

	logic              clk       = 1'b0;
	logic              arst_n    = 1'b0;
	logic              cfg_write = 1'b0;
	logic [SEED_W-1:0] cfg_data  = '0;
	logic              in_valid  = 1'b0;
	logic              in_stall;
	logic              restart   = 1'b0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	word_t             value;

	bit                idle_on     = 1'b1;
	bit                hold_output = 1'b0;
	srg_scoreboard     sb;

	subtractive_random_generator_core DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.restart   (restart),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.value     (value)
	);

	always #5 clk = ~clk;

	initial begin
		#5ms;
		$display("Test completed with failures");
		$finish;
	end

	// Offer one word and hold it until taken; maybe pause afterwards.
	task automatic send_word(bit restart_req);
		in_valid <= 1'b1;
		restart  <= restart_req;
		@(posedge clk);
		while (in_stall) begin
			@(posedge clk);
		end
		sb.note_draw(restart_req);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			restart  <= 1'($urandom_range(0, 1));
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
	endtask

	task automatic run_draws(int count);
		for (int i = 0; i < count; i++) begin
			send_word($urandom_range(0, 99) < RESTART_PCT);
		end
		in_valid <= 1'b0;
	endtask

	task automatic wait_idle();
		while (sb.outstanding() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_seed(logic [SEED_W-1:0] mag);
		cfg_write <= 1'b1;
		cfg_data  <= mag;
		@(posedge clk);
		cfg_write <= 1'b0;
		sb.set_seed(mag);
	endtask

	// Result side: random stall bursts, or one long hold on request.
	initial begin
		bit hold_done;
		hold_done = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_output && !hold_done) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				out_stall <= 1'b0;
				hold_done = 1'b1;
			end else if (idle_on && $urandom_range(0, 4) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 7)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			sb.check_value(value);
		end
	end

	initial begin
		sb = new();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset seed; first draw seeds on its own
		send_word(1'b0);
		send_word(1'b0);
		send_word(1'b0);
		send_word(1'b1);
		send_word(1'b0);
		in_valid <= 1'b0;
		wait_idle();

		// new seed is only picked up at the next reseed
		write_seed('0);
		send_word(1'b0);
		send_word(1'b1);
		send_word(1'b0);
		in_valid <= 1'b0;
		wait_idle();

		write_seed(SEED_BASE);
		send_word(1'b1);
		send_word(1'b0);
		in_valid <= 1'b0;
		wait_idle();

		// just above range: saturates
		write_seed(SEED_BASE + 1'b1);
		send_word(1'b1);
		send_word(1'b0);
		in_valid <= 1'b0;
		wait_idle();

		write_seed('1);
		send_word(1'b1);
		send_word(1'b0);
		send_word(1'b1);
		send_word(1'b1);
		in_valid <= 1'b0;
		wait_idle();

		write_seed(SEED_W'($urandom_range(0, 2**SEED_W - 1)));
		run_draws(ITEMS_PER_SEED);
		wait_idle();

		write_seed(SEED_W'(1));
		run_draws(ITEMS_PER_SEED);
		wait_idle();

		// long receiver hold while words keep coming
		write_seed(SEED_BASE);
		hold_output = 1'b1;
		run_draws(ITEMS_PER_SEED);
		wait_idle();

		write_seed(SEED_W'($urandom_range(0, 2**SEED_W - 1)));
		run_draws(ITEMS_PER_SEED);
		wait_idle();

		write_seed('1);
		run_draws(ITEMS_PER_SEED);
		wait_idle();

		idle_on = 1'b0;
		write_seed(SEED_W'($urandom_range(0, SEED_BASE)));
		run_draws(ITEMS_PER_SEED);
		wait_idle();

		if (sb.errors == 0 && sb.outstanding() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
